// ===== rtl/i2c_mrr_pkg.sv =====
`timescale 1ns / 1ps

package i2c_mrr_pkg;

  // Reset value of the acknowledge timeout register
  localparam logic [7:0] AckTimeoutReset = 8'd200;
  // Top bit of a byte, shifted down to pick the bit on the wire
  localparam logic [7:0] MsbMask = 8'h80;

  // Bus sequencer phases, one-hot
  typedef enum logic [16:0] {
    PhIdle = 17'h00001,
    PhSt0  = 17'h00002,
    PhSt1  = 17'h00004,
    PhSt2  = 17'h00008,
    PhTxl  = 17'h00010,
    PhTxd  = 17'h00020,
    PhTxh  = 17'h00040,
    PhAkr  = 17'h00080,
    PhAkh  = 17'h00100,
    PhAkp  = 17'h00200,
    PhRxl  = 17'h00400,
    PhRxh  = 17'h00800,
    PhKl   = 17'h01000,
    PhKh   = 17'h02000,
    PhSp0  = 17'h04000,
    PhSp1  = 17'h08000,
    PhSp2  = 17'h10000
  } phase_e;

  // Which byte of the transfer is in flight
  typedef enum logic [2:0] {
    StepAddrW = 3'd0,
    StepReg   = 3'd1,
    StepAddrR = 3'd2,
    StepRd1   = 3'd3,
    StepRd2   = 3'd4,
    StepErr   = 3'd7
  } step_e;

  // One input beat
  typedef struct packed {
    logic       opcode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       sda_in;
  } item_t;

  // One result beat
  typedef struct packed {
    logic        scl_level;
    logic        sda_drive;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [15:0] read_data;
  } result_t;

  // Bit of the byte sent at position idx, MSB first
  function automatic logic tx_bit(logic [7:0] shift, logic [2:0] idx);
    tx_bit = |(shift & (MsbMask >> idx));
  endfunction

endpackage

// ===== rtl/i2c_master_register_read.sv =====
`timescale 1ns / 1ps

// I2C master, two-byte register read, one bus delay phase per input beat.
// Input channel (in_valid_i / in_stall_o): opcode_i = 1 in idle starts a
//   transfer and latches dev_addr_i and reg_addr_i; every beat is one tick
//   and carries the sampled SDA level on sda_in_i.
// Output channel (out_valid_o / out_stall_i): exactly one result beat per
//   input beat, in order: SCL/SDA levels for the next phase, busy, a done
//   pulse with status (1 = acknowledge timeout) and the received word.
// Config channel (cfg_valid_i / cfg_ready_o, always ready): cfg_data_i sets
//   the acknowledge timeout in polls; write it only while idle.
// Path: an input beat passes the input register, one pass through the phase
//   logic and the result register before it appears as a result beat.
// Throughput: one beat per cycle while the output is not stalled; the phase
//   update is one step of the sequencer, so beats may follow back to back.
// Stall: when the result register is full and stalled, a beat waiting in the
//   input register holds and in_stall_o rises the same cycle; nothing is
//   dropped.
// Reset: sequencer idle, both pipeline registers empty, timeout 200.
module i2c_master_register_read import i2c_mrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_level_o,
  output logic        sda_drive_o,
  output logic        sda_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        status_o,
  output logic [15:0] read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    advance;

  assign advance     = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.opcode   <= opcode_i;
      item_q.dev_addr <= dev_addr_i;
      item_q.reg_addr <= reg_addr_i;
      item_q.sda_in   <= sda_in_i;
    end
  end

  i2c_mrr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (item_q),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = res_q.scl_level;
  assign sda_drive_o = res_q.sda_drive;
  assign sda_level_o = res_q.sda_level;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign status_o    = res_q.status;
  assign read_data_o = res_q.read_data;

endmodule

// ===== rtl/i2c_mrr_core.sv =====
`timescale 1ns / 1ps

module i2c_mrr_core import i2c_mrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  item_t      item_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  step_e       step_q, step_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic [6:0]  slave_q, slave_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] word_q, word_d;
  logic [7:0]  timeout_q;
  logic [7:0]  rx_byte;
  logic        scl, drv, lvl, done, stat;

  assign rx_byte = {shift_q[6:0], item_i.sda_in};

  // Next state and bus levels for one tick
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    slave_d = slave_q;
    reg_d   = reg_q;
    word_d  = word_q;
    scl  = 1'b1;
    drv  = 1'b1;
    lvl  = 1'b1;
    done = 1'b0;
    stat = 1'b0;
    unique case (phase_q)
      PhSt0: begin
        phase_d = PhSt1;
      end
      PhSt1: begin
        lvl     = 1'b0;
        phase_d = PhSt2;
      end
      PhSt2: begin
        scl     = 1'b0;
        lvl     = 1'b0;
        shift_d = {slave_q, step_q == StepAddrR};
        bit_d   = 4'd0;
        phase_d = PhTxl;
      end
      PhTxl: begin
        scl = 1'b0;
        if (bit_q == 4'd0) begin
          lvl = (step_q == StepReg);
        end else begin
          lvl = tx_bit(shift_q, bit_q[2:0] - 3'd1);
        end
        phase_d = PhTxd;
      end
      PhTxd: begin
        scl     = 1'b0;
        lvl     = tx_bit(shift_q, bit_q[2:0]);
        phase_d = PhTxh;
      end
      PhTxh: begin
        lvl = tx_bit(shift_q, bit_q[2:0]);
        if (bit_q >= 4'd7) begin
          bit_d   = 4'd0;
          phase_d = PhAkr;
        end else begin
          bit_d   = bit_q + 4'd1;
          phase_d = PhTxl;
        end
      end
      PhAkr: begin
        scl     = 1'b0;
        drv     = 1'b0;
        lvl     = 1'b0;
        phase_d = PhAkh;
      end
      PhAkh: begin
        drv     = 1'b0;
        lvl     = 1'b0;
        poll_d  = 8'd0;
        phase_d = PhAkp;
      end
      PhAkp: begin
        if (!item_i.sda_in) begin
          // acknowledge seen: pull SCL low and move to the next byte
          scl   = 1'b0;
          drv   = 1'b0;
          lvl   = 1'b0;
          bit_d = 4'd0;
          if (step_q == StepAddrW) begin
            step_d  = StepReg;
            shift_d = reg_q;
            phase_d = PhTxl;
          end else if (step_q == StepReg) begin
            step_d  = StepAddrR;
            phase_d = PhSt0;
          end else begin
            step_d  = StepRd1;
            shift_d = 8'd0;
            phase_d = PhRxl;
          end
        end else if (poll_q == timeout_q) begin
          // timeout: this tick is the first STOP phase
          scl     = 1'b0;
          lvl     = 1'b0;
          step_d  = StepErr;
          phase_d = PhSp1;
        end else begin
          drv    = 1'b0;
          lvl    = 1'b0;
          poll_d = poll_q + 8'd1;
        end
      end
      PhRxl: begin
        scl     = 1'b0;
        drv     = 1'b0;
        lvl     = 1'b0;
        phase_d = PhRxh;
      end
      PhRxh: begin
        drv     = 1'b0;
        lvl     = 1'b0;
        shift_d = rx_byte;
        if (bit_q >= 4'd7) begin
          bit_d = 4'd0;
          if (step_q == StepRd1) begin
            word_d = {rx_byte, word_q[7:0]};
          end else begin
            word_d = {word_q[15:8], rx_byte};
          end
          phase_d = PhKl;
        end else begin
          bit_d   = bit_q + 4'd1;
          phase_d = PhRxl;
        end
      end
      PhKl: begin
        // ACK after the first byte, NACK after the second
        lvl     = (step_q != StepRd1);
        scl     = 1'b0;
        phase_d = PhKh;
      end
      PhKh: begin
        lvl = (step_q != StepRd1);
        if (step_q == StepRd1) begin
          step_d  = StepRd2;
          shift_d = 8'd0;
          phase_d = PhRxl;
        end else begin
          phase_d = PhSp0;
        end
      end
      PhSp0: begin
        scl     = 1'b0;
        lvl     = 1'b0;
        phase_d = PhSp1;
      end
      PhSp1: begin
        lvl     = 1'b0;
        phase_d = PhSp2;
      end
      PhSp2: begin
        done    = 1'b1;
        stat    = (step_q == StepErr);
        phase_d = PhIdle;
      end
      default: begin
        // idle: lines high, a start command latches the addresses
        phase_d = PhIdle;
        if (item_i.opcode) begin
          slave_d = item_i.dev_addr;
          reg_d   = item_i.reg_addr;
          word_d  = 16'd0;
          step_d  = StepAddrW;
          bit_d   = 4'd0;
          poll_d  = 8'd0;
          shift_d = 8'd0;
          phase_d = PhSt1;
        end
      end
    endcase
  end

  always_comb begin
    res_o.scl_level = scl;
    res_o.sda_drive = drv;
    res_o.sda_level = lvl;
    res_o.busy_res  = (phase_d != PhIdle);
    res_o.done_res  = done;
    res_o.status    = stat;
    res_o.read_data = word_d;
  end

  // Sequencer state, advanced once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      step_q  <= StepAddrW;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      poll_q  <= 8'd0;
      slave_q <= 7'd0;
      reg_q   <= 8'd0;
      word_q  <= 16'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      slave_q <= slave_d;
      reg_q   <= reg_d;
      word_q  <= word_d;
    end
  end

  // Acknowledge timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_data_i;
    end
  end

endmodule

// ===== rtl/i2c_mrr_checker.sv =====
`timescale 1ns / 1ps

module i2c_mrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        scl_level_o,
  input logic        sda_drive_o,
  input logic        sda_level_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic        status_o,
  input logic [15:0] read_data_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o)
      && $stable(done_res_o) && $stable(scl_level_o))
    else $error("result beat changed under stall");

  // Input only backs up behind a stalled, full result register
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Timeout status only on the closing beat
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> done_res_o && !busy_res_o)
    else $error("status without done");

  // Idle bus: both lines driven high
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> scl_level_o && sda_drive_o && sda_level_o)
    else $error("bus not released high while idle");

endmodule

bind i2c_master_register_read i2c_mrr_checker u_i2c_mrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .scl_level_o (scl_level_o),
  .sda_drive_o (sda_drive_o),
  .sda_level_o (sda_level_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .status_o    (status_o),
  .read_data_o (read_data_o)
);
